@@ rtl/llra_pkg.sv @@
// shared types and constants of the least-loaded row assigner
package llra_pkg;

  // configuration register indexes
  localparam logic [3:0] REG_ROW_COUNT = 4'd0;
  localparam logic [3:0] REG_PADDING   = 4'd1;

  // fixed field widths
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int ROW_COUNT_W = 5;
  localparam int PAD_W       = 8;
  localparam int ITEM_W      = 12;
  localparam int ROW_IDX_W   = 4;
  localparam int WIDEST_W    = 16;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 24;

  // per-cell control from the sequencer
  typedef struct packed {
    logic active;  // cell takes part in the scan
    logic load;    // reload width with padding
    logic write;   // store the new width of the chosen row
  } llra_ctrl_t;

endpackage

@@ rtl/llra_cell.sv @@
// one row cell: holds a row width and passes the running min/max scan onward
module llra_cell import llra_pkg::*; #(
  parameter int RW       = 16,
  parameter int IW       = 4,
  parameter int CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  llra_ctrl_t    ctrl_i,
  input  logic [RW-1:0] load_val_i,
  input  logic [RW-1:0] wr_val_i,
  input  logic          scan_valid_i,
  input  logic [RW-1:0] scan_min_i,
  input  logic [IW-1:0] scan_idx_i,
  input  logic [RW-1:0] scan_max_i,
  output logic          scan_valid_o,
  output logic [RW-1:0] scan_min_o,
  output logic [IW-1:0] scan_idx_o,
  output logic [RW-1:0] scan_max_o
);

  logic [RW-1:0] width_q;
  logic          valid_q;
  logic [RW-1:0] min_q, min_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [RW-1:0] max_q, max_d;

  // row width storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
    end else if (ctrl_i.load) begin
      width_q <= load_val_i;
    end else if (ctrl_i.write) begin
      width_q <= wr_val_i;
    end
  end

  // compare against the running scan, strict less keeps the lowest index on ties
  always_comb begin
    min_d = scan_min_i;
    idx_d = scan_idx_i;
    max_d = scan_max_i;
    if (ctrl_i.active) begin
      if (width_q < scan_min_i) begin
        min_d = width_q;
        idx_d = IW'(CELL_IDX);
      end
      if (width_q > scan_max_i) begin
        max_d = width_q;
      end
    end
  end

  // scan stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= scan_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    idx_q <= idx_d;
    max_q <= max_d;
  end

  assign scan_valid_o = valid_q;
  assign scan_min_o   = min_q;
  assign scan_idx_o   = idx_q;
  assign scan_max_o   = max_q;

endmodule

@@ rtl/least_loaded_row_assigner_core.sv @@
// top level: row cell chain, sequencer, config registers and stream ports
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: item_width[11:0], zero[15:12]; tlast: last_item
// m_axis  | out | tdata: row_index[3:0], widest_row[19:4], zero[23:20]; tuser: set_done
// cfg     | in  | cfg_index_i 0: row_count, 1: padding; cfg_data_i value
//
// an item passes one scan hop per row cell, then the add and saturate
// stage, then the write-back into the chosen cell
// the next item is taken in the cycle after write-back, even while the result waits
// write-back stalls only while the previous result is still held on m_axis
// reset loads every row width with zero (the reset padding), no clearing pass
// a row_count or padding write reloads all rows with the padding value
module least_loaded_row_assigner_core import llra_pkg::*; #(
  parameter int MAX_ROWS       = 16,
  parameter int ROW_WIDTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // item_width[11:0], zero[15:12]
  input  logic                  s_axis_tlast,   // last_item
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // row_index[3:0], widest_row[19:4], zero
  output logic                  m_axis_tuser    // set_done
);

  localparam int RW = ROW_WIDTH_BITS;
  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = RW + 13;
  localparam int XW = (RW > WIDEST_W) ? RW : WIDEST_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0] state_q, state_d;

  logic [ROW_COUNT_W-1:0] row_count_q;
  logic [PAD_W-1:0]       padding_q;

  logic [ITEM_W-1:0] item_q;
  logic              last_q;

  logic [RW-1:0] sum_q;
  logic [IW-1:0] best_q;
  logic [RW-1:0] maxb_q;

  logic                 out_valid_q;
  logic [ROW_IDX_W-1:0] out_idx_q;
  logic [WIDEST_W-1:0]  out_widest_q;
  logic                 out_done_q;

  logic s_hs, out_free, wb_go, cfg_load;
  logic [RW-1:0] load_val;
  logic [7:0] rows_n;
  logic [SW-1:0] sum_full;
  logic [RW-1:0] sum_sat;
  logic [XW-1:0] widest_x;
  logic [WIDEST_W-1:0] widest_sat;
  logic [IW+ROW_IDX_W-1:0] idx_ext;

  // scan chain wires, entry 0 is the injected start of scan
  logic          ch_valid [MAX_ROWS+1];
  logic [RW-1:0] ch_min   [MAX_ROWS+1];
  logic [IW-1:0] ch_idx   [MAX_ROWS+1];
  logic [RW-1:0] ch_max   [MAX_ROWS+1];
  llra_ctrl_t    ctrl     [MAX_ROWS];
  logic [MAX_ROWS-1:0] wr_vec;

  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign wb_go    = (state_q == ST_WB) && out_free;
  assign cfg_load = cfg_we_i && ((cfg_index_i == REG_ROW_COUNT) ||
                                 (cfg_index_i == REG_PADDING));

  // rows in use, zero counts as one and large values clamp
  always_comb begin
    rows_n = 8'(row_count_q);
    if (rows_n == 8'd0) begin
      rows_n = 8'd1;
    end else if (rows_n > 8'(MAX_ROWS)) begin
      rows_n = 8'(MAX_ROWS);
    end
  end

  // reload value: new padding on a padding write, else the current one
  assign load_val = (cfg_we_i && (cfg_index_i == REG_PADDING)) ?
                    RW'(cfg_data_i) : RW'(padding_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_W'(1);
      padding_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ROW_COUNT) begin
        row_count_q <= cfg_data_i[ROW_COUNT_W-1:0];
      end else if (cfg_index_i == REG_PADDING) begin
        padding_q <= cfg_data_i[PAD_W-1:0];
      end
    end
  end

  // scan injection at the input transaction
  assign ch_valid[0] = s_hs;
  assign ch_min[0]   = '1;
  assign ch_idx[0]   = '0;
  assign ch_max[0]   = '0;

  // row cells
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    assign wr_vec[g]     = wb_go && !last_q && (best_q == IW'(g));
    assign ctrl[g].active = (8'(g) < rows_n);
    assign ctrl[g].load   = cfg_load || (wb_go && last_q);
    assign ctrl[g].write  = wr_vec[g];

    llra_cell #(
      .RW       (RW),
      .IW       (IW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .load_val_i   (load_val),
      .wr_val_i     (sum_q),
      .scan_valid_i (ch_valid[g]),
      .scan_min_i   (ch_min[g]),
      .scan_idx_i   (ch_idx[g]),
      .scan_max_i   (ch_max[g]),
      .scan_valid_o (ch_valid[g+1]),
      .scan_min_o   (ch_min[g+1]),
      .scan_idx_o   (ch_idx[g+1]),
      .scan_max_o   (ch_max[g+1])
    );
  end

  // add item width and padding to the lightest row, saturating
  assign sum_full = SW'(ch_min[MAX_ROWS]) + SW'(item_q) + SW'(padding_q);
  assign sum_sat  = (sum_full > SW'({RW{1'b1}})) ? '1 : sum_full[RW-1:0];

  // widest row after placement, clamped to the result field
  always_comb begin
    widest_x = (sum_q > maxb_q) ? XW'(sum_q) : XW'(maxb_q);
    if (widest_x > XW'({WIDEST_W{1'b1}})) begin
      widest_sat = '1;
    end else begin
      widest_sat = widest_x[WIDEST_W-1:0];
    end
  end

  assign idx_ext = (IW+ROW_IDX_W)'(best_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_hs) state_d = ST_SCAN;
      ST_SCAN: if (ch_valid[MAX_ROWS]) state_d = ST_WB;
      ST_WB:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      item_q <= s_axis_tdata[ITEM_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  // scan result capture
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && ch_valid[MAX_ROWS]) begin
      sum_q  <= sum_sat;
      best_q <= ch_idx[MAX_ROWS];
      maxb_q <= ch_max[MAX_ROWS];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_idx_q    <= idx_ext[ROW_IDX_W-1:0];
      out_widest_q <= last_q ? widest_sat : '0;
      out_done_q   <= last_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_widest_q, out_idx_q};
  assign m_axis_tuser  = out_done_q;

  // the scan only reaches the chain end while the sequencer waits for it
  a_scan_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid[MAX_ROWS] |-> (state_q == ST_SCAN))
    else $error("scan result outside scan state");

  // at most one row cell is written per item
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_vec))
    else $error("more than one row written");

  // a result that does not close a set carries no widest row
  a_widest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[19:4] == '0))
    else $error("widest row set on a non-final result");

  // write-back never overwrites a result still waiting on the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule

@@ bench/tb_least_loaded_row_assigner_core.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the least-loaded row assigner core
module tb_least_loaded_row_assigner_core import llra_pkg::*; ();

  localparam int NUM_ROWS    = 16;
  localparam int ROW_W       = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 850;
  localparam int END_WAIT    = 40;

  localparam logic [ROW_W-1:0] ROW_CEIL = '1;

  // indexes past the register list, writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [WIDEST_W-1:0]  widest_row;
    logic                 set_done;
  } placement_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // item_width[11:0], zero[15:12]
  logic                  s_axis_tlast;   // last_item
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // row_index[3:0], widest_row[19:4], zero[23:20]
  logic                  m_axis_tuser;   // set_done

  // predicted row loads and register copies
  logic [ROW_W-1:0]       row_load [NUM_ROWS];
  logic [ROW_COUNT_W-1:0] row_count_q;
  logic [PAD_W-1:0]       pad_q;
  placement_t             placements_due[$];

  int items_sent   = 0;
  int sets_closed  = 0;
  int results_seen = 0;
  int ceiling_hits = 0;
  int phases       = 0;
  int errors       = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  bit no_idle      = 1'b0;

  least_loaded_row_assigner_core #(
    .MAX_ROWS      (NUM_ROWS),
    .ROW_WIDTH_BITS(ROW_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // zero count means one row, counts past the row store are clamped
  function automatic int rows_in_use();
    if (row_count_q == 0) return 1;
    if (row_count_q > NUM_ROWS) return NUM_ROWS;
    return int'(row_count_q);
  endfunction

  function automatic void reload_rows();
    for (int i = 0; i < NUM_ROWS; i++) row_load[i] = ROW_W'(pad_q);
  endfunction

  // greedy placement onto the lightest row, lowest index wins ties
  function automatic placement_t place_item(input logic [ITEM_W-1:0] width, input logic last);
    placement_t       res;
    int               n;
    int               best;
    logic [ROW_W+1:0] sum;
    logic [ROW_W-1:0] widest;
    n = rows_in_use();
    best = 0;
    for (int i = 1; i < n; i++)
      if (row_load[i] < row_load[best]) best = i;
    sum = (ROW_W+2)'(row_load[best]) + (ROW_W+2)'(width) + (ROW_W+2)'(pad_q);
    if (sum > ROW_CEIL) begin
      sum = (ROW_W+2)'(ROW_CEIL);
      ceiling_hits++;
    end
    row_load[best] = sum[ROW_W-1:0];
    res.row_index = best[ROW_IDX_W-1:0];
    res.widest_row = '0;
    res.set_done = 1'b0;
    if (last) begin
      widest = '0;
      for (int i = 0; i < n; i++)
        if (row_load[i] > widest) widest = row_load[i];
      res.widest_row = widest;
      res.set_done = 1'b1;
      reload_rows();
    end
    return res;
  endfunction

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic logic [ITEM_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ITEM_W'($urandom_range(0, 15));
      default: return ITEM_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // one register write, only issued while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROW_COUNT: begin
        row_count_q = val[ROW_COUNT_W-1:0];
        reload_rows();
      end
      REG_PADDING: begin
        pad_q = val;
        reload_rows();
      end
      default: ;
    endcase
  endtask

  // one input transaction with a random lead-in gap
  task automatic send_item(input logic [ITEM_W-1:0] width, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-ITEM_W){1'b0}}, width};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    placements_due.insert(placements_due.size(), place_item(width, last));
    items_sent++;
    if (last) sets_closed++;
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
  endtask

  // reset values: one row, no padding
  task automatic test_reset_defaults();
    send_item(12'd0, 1'b0);
    send_item(12'hFFF, 1'b1);
    drain();
  endtask

  // equal loads go to the lowest row, then the lightest row wins
  task automatic test_tie_break();
    write_reg(REG_ROW_COUNT, 8'd4);
    write_reg(REG_PADDING, 8'd255);
    send_item(12'hFFF, 1'b0);
    send_item(12'd0, 1'b0);
    send_item(12'd100, 1'b0);
    send_item(12'd0, 1'b0);
    send_item(12'd7, 1'b1);
    drain();
  endtask

  // zero count, ignored indexes, count past the row store
  task automatic test_row_limits();
    int k;
    write_reg(REG_ROW_COUNT, 8'd0);
    send_item(12'd5, 1'b0);
    drain();
    // unused indexes must leave the open set untouched
    write_reg(REG_UNUSED_LO, 8'hAA);
    write_reg(REG_UNUSED_HI, 8'h55);
    send_item(12'd9, 1'b1);
    drain();
    // all data bits high: count masks to 31, clamped to the full row store
    write_reg(REG_ROW_COUNT, 8'hFF);
    for (k = 0; k < NUM_ROWS - 1; k++) send_item(12'd1, 1'b0);
    send_item(12'hFFF, 1'b1);
    drain();
  endtask

  // random configs with sets of random content, some heavy, some broken
  task automatic test_random_sets();
    int                    flavor;
    int                    len;
    int                    k;
    logic                  last;
    logic [CFG_DATA_W-1:0] rc;
    logic [CFG_DATA_W-1:0] pad;
    while (items_sent < ITEM_TARGET) begin
      phases++;
      no_idle = ($urandom_range(0, 3) == 0);
      flavor = $urandom_range(0, 9);
      case ($urandom_range(0, 9))
        0:       rc = 8'd0;
        1:       rc = CFG_DATA_W'($urandom_range(17, 31));
        2:       rc = CFG_DATA_W'($urandom_range(0, 255));
        3:       rc = 8'd16;
        4:       rc = 8'd1;
        default: rc = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       pad = 8'd0;
        1:       pad = 8'd255;
        default: pad = CFG_DATA_W'($urandom_range(0, 255));
      endcase
      // heavy sets drive rows into the width ceiling
      if (flavor < 2) begin
        rc = CFG_DATA_W'($urandom_range(1, 2));
        pad = CFG_DATA_W'($urandom_range(200, 255));
      end
      if (flavor < 2) begin
        write_reg(REG_PADDING, pad);
        write_reg(REG_ROW_COUNT, rc);
      end else begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_ROW_COUNT, rc);
          1:       write_reg(REG_PADDING, pad);
          default: begin
            write_reg(REG_PADDING, pad);
            write_reg(REG_ROW_COUNT, rc);
          end
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  CFG_DATA_W'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 4)) begin
        if (flavor < 2) len = $urandom_range(16, 30);
        else if (flavor == 2) len = $urandom_range(3, 15);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          // noise sets carry random last flags, possibly leaving the set open
          if (flavor == 2) last = ($urandom_range(0, 1) == 1);
          else last = (k == len - 1);
          if (flavor < 2) send_item(ITEM_W'($urandom_range(3000, 4095)), last);
          else send_item(pick_width(), last);
        end
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // result side backpressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (placements_due.size() == 0) begin
        $error("result transaction with no placement pending");
        errors++;
      end else begin
        want = placements_due.pop_front();
        results_seen++;
        if (m_axis_tdata[ROW_IDX_W-1:0] !== want.row_index) begin
          $error("row_index: expected %0d, actual %0d",
                 want.row_index, m_axis_tdata[ROW_IDX_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[ROW_IDX_W +: WIDEST_W] !== want.widest_row) begin
          $error("widest_row: expected %0d, actual %0d",
                 want.widest_row, m_axis_tdata[ROW_IDX_W +: WIDEST_W]);
          errors++;
        end
        if (m_axis_tuser !== want.set_done) begin
          $error("set_done: expected %0d, actual %0d", want.set_done, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** least_loaded_row_assigner_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    row_count_q = 5'd1;
    pad_q = '0;
    reload_rows();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_tie_break();
    test_row_limits();
    test_random_sets();

    repeat (END_WAIT) @(posedge clk_i);

    $display("placed %0d items in %0d closed sets over %0d random config phases",
             items_sent, sets_closed, phases);
    $display("%0d results checked, %0d placements clamped at the row width ceiling",
             results_seen, ceiling_hits);
    if (errors == 0) begin
      $display("** least_loaded_row_assigner_core: PASSED **");
    end else begin
      $display("** least_loaded_row_assigner_core: FAILED **");
    end
    $finish;
  end

endmodule
